FILE: rtl/assert_macros.svh
// assertion macros shared by the polygon area blocks
// expects i_clk and i_rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pab_pkg.sv
// polygon area and bounds: shared types, sum limits and clamp helpers
// no dependencies
package pab_pkg;

    localparam int SUM_BITS  = 64;
    localparam int AREA_BITS = 63;

    typedef logic signed [SUM_BITS-1:0] t_sum;
    typedef logic signed [SUM_BITS:0]   t_sum_x1;
    typedef logic signed [SUM_BITS+1:0] t_sum_x2;
    typedef logic [AREA_BITS-1:0]       t_area;

    localparam t_sum  SUM_MAX  = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam t_sum  SUM_MIN  = {1'b1, {(SUM_BITS-1){1'b0}}};
    localparam t_area AREA_MAX = '1;

    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

    function automatic logic sum_fits(input t_sum_x2 v);
        return (v[SUM_BITS+1:SUM_BITS-1] == 3'b000) || (v[SUM_BITS+1:SUM_BITS-1] == 3'b111);
    endfunction

    function automatic t_sum clamp_sum(input t_sum_x2 v);
        t_sum res;
        if (sum_fits(v)) begin
            res = v[SUM_BITS-1:0];
        end else if (v[SUM_BITS+1]) begin
            res = SUM_MIN;
        end else begin
            res = SUM_MAX;
        end
        return res;
    endfunction

endpackage

FILE: rtl/pab_vertex_if.sv
// vertex channel: valid/ready handshake with coordinates and end marks
// no dependencies
interface pab_vertex_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last_of_contour;
    logic                         last_of_polygon;

    modport source (output valid, x, y, last_of_contour, last_of_polygon, input ready);
    modport sink   (input valid, x, y, last_of_contour, last_of_polygon, output ready);
endinterface

FILE: rtl/pab_result_if.sv
// result channel: valid/ready handshake with area, bounding box and flags
// no dependencies
interface pab_result_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic [62:0]                  twice_area;
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] max_y;
    logic                         no_vertices;
    logic                         overflowed;

    modport source (output valid, twice_area, min_x, min_y, max_x, max_y, no_vertices,
                    overflowed, input ready);
    modport sink   (input valid, twice_area, min_x, min_y, max_x, max_y, no_vertices,
                    overflowed, output ready);
endinterface

FILE: rtl/pab_vertex_stage.sv
// input register, contour tracking, shoelace products and bounding box
// depends on pab_pkg and assert_macros.svh
`include "assert_macros.svh"
module pab_vertex_stage #(parameter int COORD_BITS = 24) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic                         i_eoc,
    input  logic                         i_eop,
    output pab_pkg::t_stage_ctl          o_ctl,
    output pab_pkg::t_sum                o_edge,
    output pab_pkg::t_sum                o_close,
    output logic signed [COORD_BITS-1:0] o_min_x,
    output logic signed [COORD_BITS-1:0] o_min_y,
    output logic signed [COORD_BITS-1:0] o_max_x,
    output logic signed [COORD_BITS-1:0] o_max_y
);
    import pab_pkg::*;

    localparam int CB = COORD_BITS;
    localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

    t_stage_ctl            r_a_ctl, r_b_ctl;
    logic signed [CB-1:0]  r_a_x, r_a_y;
    logic                  r_a_end;
    logic                  r_starting;
    logic signed [CB-1:0]  r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic signed [CB-1:0]  r_low_x, r_low_y, r_high_x, r_high_y;
    t_sum                  r_b_edge, r_b_close;
    logic signed [CB-1:0]  r_b_min_x, r_b_min_y, r_b_max_x, r_b_max_y;

    logic signed [CB-1:0]  w_fx, w_fy;
    logic signed [CB:0]    w_sx1, w_dy1, w_sx2, w_dy2;
    logic signed [2*CB+1:0] w_p1, w_p2;
    logic signed [CB-1:0]  w_low_x, w_low_y, w_high_x, w_high_y;

    // a contour's first vertex closes onto itself
    assign w_fx = r_starting ? r_a_x : r_first_x;
    assign w_fy = r_starting ? r_a_y : r_first_y;

    assign w_sx1 = {r_prev_x[CB-1], r_prev_x} + {r_a_x[CB-1], r_a_x};
    assign w_dy1 = {r_prev_y[CB-1], r_prev_y} - {r_a_y[CB-1], r_a_y};
    assign w_sx2 = {r_a_x[CB-1], r_a_x} + {w_fx[CB-1], w_fx};
    assign w_dy2 = {r_a_y[CB-1], r_a_y} - {w_fy[CB-1], w_fy};
    assign w_p1  = w_sx1 * w_dy1;
    assign w_p2  = w_sx2 * w_dy2;

    assign w_low_x  = (r_a_x < r_low_x)  ? r_a_x : r_low_x;
    assign w_low_y  = (r_a_y < r_low_y)  ? r_a_y : r_low_y;
    assign w_high_x = (r_a_x > r_high_x) ? r_a_x : r_high_x;
    assign w_high_y = (r_a_y > r_high_y) ? r_a_y : r_high_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl    <= '0;
            r_b_ctl    <= '0;
            r_starting <= 1'b1;
            r_low_x    <= CMAX;
            r_low_y    <= CMAX;
            r_high_x   <= CMIN;
            r_high_y   <= CMIN;
        end else if (i_adv) begin
            r_a_ctl.valid <= i_valid;
            r_a_ctl.last  <= i_eop;
            r_b_ctl       <= r_a_ctl;
            if (r_a_ctl.valid) begin
                r_starting <= r_a_end;
                if (r_a_ctl.last) begin
                    r_low_x  <= CMAX;
                    r_low_y  <= CMAX;
                    r_high_x <= CMIN;
                    r_high_y <= CMIN;
                end else begin
                    r_low_x  <= w_low_x;
                    r_low_y  <= w_low_y;
                    r_high_x <= w_high_x;
                    r_high_y <= w_high_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_x   <= i_x;
            r_a_y   <= i_y;
            r_a_end <= i_eoc | i_eop;
            if (r_a_ctl.valid) begin
                if (r_starting) begin
                    r_first_x <= r_a_x;
                    r_first_y <= r_a_y;
                end
                r_prev_x <= r_a_x;
                r_prev_y <= r_a_y;
            end
            r_b_edge  <= r_starting ? '0 : SUM_BITS'(w_p1);
            r_b_close <= r_a_end ? SUM_BITS'(w_p2) : '0;
            r_b_min_x <= w_low_x;
            r_b_min_y <= w_low_y;
            r_b_max_x <= w_high_x;
            r_b_max_y <= w_high_y;
        end
    end

    assign o_ctl   = r_b_ctl;
    assign o_edge  = r_b_edge;
    assign o_close = r_b_close;
    assign o_min_x = r_b_min_x;
    assign o_min_y = r_b_min_y;
    assign o_max_x = r_b_max_x;
    assign o_max_y = r_b_max_y;

    `ASSERT_NEXT(a_contour_flag, i_adv && r_a_ctl.valid, r_starting == $past(r_a_end), "contour start flag wrong")
    `ASSERT_IMPLIES(a_box_x, !r_starting, r_low_x <= r_high_x, "x bounds crossed inside a contour")
    `ASSERT_IMPLIES(a_box_y, !r_starting, r_low_y <= r_high_y, "y bounds crossed inside a contour")

endmodule

FILE: rtl/pab_accum.sv
// pre-add of the two shoelace terms and the saturating area accumulator
// depends on pab_pkg and assert_macros.svh
`include "assert_macros.svh"
module pab_accum #(parameter int COORD_BITS = 24) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  pab_pkg::t_stage_ctl          i_ctl,
    input  pab_pkg::t_sum                i_edge,
    input  pab_pkg::t_sum                i_close,
    input  logic signed [COORD_BITS-1:0] i_min_x,
    input  logic signed [COORD_BITS-1:0] i_min_y,
    input  logic signed [COORD_BITS-1:0] i_max_x,
    input  logic signed [COORD_BITS-1:0] i_max_y,
    output pab_pkg::t_stage_ctl          o_ctl,
    output pab_pkg::t_sum                o_sum,
    output logic                         o_sat,
    output logic signed [COORD_BITS-1:0] o_min_x,
    output logic signed [COORD_BITS-1:0] o_min_y,
    output logic signed [COORD_BITS-1:0] o_max_x,
    output logic signed [COORD_BITS-1:0] o_max_y
);
    import pab_pkg::*;

    localparam int CB = COORD_BITS;

    t_stage_ctl           r_c_ctl, r_d_ctl;
    t_sum                 r_c_edge;
    t_sum_x1              r_c_pair, r_c_hi, r_c_lo;
    logic signed [CB-1:0] r_c_min_x, r_c_min_y, r_c_max_x, r_c_max_y;
    t_sum                 r_sum;
    logic                 r_sat;
    t_sum                 r_d_sum;
    logic                 r_d_sat;
    logic signed [CB-1:0] r_d_min_x, r_d_min_y, r_d_max_x, r_d_max_y;

    t_sum_x1 w_u;
    t_sum_x2 w_w, w_v;
    logic    w_u_hi, w_u_lo;
    t_sum    n_sum;
    logic    n_ovf;

    // edge term first, closing term second, each clamped
    assign w_u    = t_sum_x1'(r_sum) + t_sum_x1'(r_c_edge);
    assign w_u_hi = (w_u[SUM_BITS:SUM_BITS-1] == 2'b01);
    assign w_u_lo = (w_u[SUM_BITS:SUM_BITS-1] == 2'b10);
    assign w_w    = t_sum_x2'(r_sum) + t_sum_x2'(r_c_pair);

    always_comb begin
        priority if (w_u_hi) begin
            w_v = t_sum_x2'(r_c_hi);
        end else if (w_u_lo) begin
            w_v = t_sum_x2'(r_c_lo);
        end else begin
            w_v = w_w;
        end
    end

    assign n_sum = clamp_sum(w_v);
    assign n_ovf = w_u_hi | w_u_lo | !sum_fits(w_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
            r_d_ctl <= '0;
            r_sum   <= '0;
            r_sat   <= 1'b0;
        end else if (i_adv) begin
            r_c_ctl       <= i_ctl;
            r_d_ctl.valid <= r_c_ctl.valid & r_c_ctl.last;
            r_d_ctl.last  <= r_c_ctl.last;
            if (r_c_ctl.valid) begin
                if (r_c_ctl.last) begin
                    r_sum <= '0;
                    r_sat <= 1'b0;
                end else begin
                    r_sum <= n_sum;
                    r_sat <= r_sat | n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c_edge  <= i_edge;
            r_c_pair  <= t_sum_x1'(i_edge) + t_sum_x1'(i_close);
            r_c_hi    <= t_sum_x1'(SUM_MAX) + t_sum_x1'(i_close);
            r_c_lo    <= t_sum_x1'(SUM_MIN) + t_sum_x1'(i_close);
            r_c_min_x <= i_min_x;
            r_c_min_y <= i_min_y;
            r_c_max_x <= i_max_x;
            r_c_max_y <= i_max_y;
            r_d_sum   <= n_sum;
            r_d_sat   <= r_sat | n_ovf;
            r_d_min_x <= r_c_min_x;
            r_d_min_y <= r_c_min_y;
            r_d_max_x <= r_c_max_x;
            r_d_max_y <= r_c_max_y;
        end
    end

    assign o_ctl   = r_d_ctl;
    assign o_sum   = r_d_sum;
    assign o_sat   = r_d_sat;
    assign o_min_x = r_d_min_x;
    assign o_min_y = r_d_min_y;
    assign o_max_x = r_d_max_x;
    assign o_max_y = r_d_max_y;

    `ASSERT_NEXT(a_clear_on_end, i_adv && r_c_ctl.valid && r_c_ctl.last, (r_sum == '0) && !r_sat, "sum not cleared at polygon end")
    `ASSERT_NEXT(a_hold_on_stall, !i_adv, $stable(r_sum) && $stable(r_sat), "sum moved while stalled")
    `ASSERT_NEXT(a_result_only_at_end, i_adv && !(r_c_ctl.valid && r_c_ctl.last), !r_d_ctl.valid, "result raised without polygon end")

endmodule

FILE: rtl/pab_result.sv
// magnitude of the final sum and the output register
// depends on pab_pkg
module pab_result #(parameter int COORD_BITS = 24) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  pab_pkg::t_stage_ctl          i_ctl,
    input  pab_pkg::t_sum                i_sum,
    input  logic                         i_sat,
    input  logic signed [COORD_BITS-1:0] i_min_x,
    input  logic signed [COORD_BITS-1:0] i_min_y,
    input  logic signed [COORD_BITS-1:0] i_max_x,
    input  logic signed [COORD_BITS-1:0] i_max_y,
    output logic                         o_valid,
    output pab_pkg::t_area               o_twice_area,
    output logic signed [COORD_BITS-1:0] o_min_x,
    output logic signed [COORD_BITS-1:0] o_min_y,
    output logic signed [COORD_BITS-1:0] o_max_x,
    output logic signed [COORD_BITS-1:0] o_max_y,
    output logic                         o_no_vertices,
    output logic                         o_overflowed
);
    import pab_pkg::*;

    localparam int CB = COORD_BITS;

    logic                 r_valid;
    t_area                r_area;
    logic                 r_ovf;
    logic signed [CB-1:0] r_min_x, r_min_y, r_max_x, r_max_y;

    t_sum  w_neg;
    t_area w_mag;

    assign w_neg = -i_sum;

    always_comb begin
        priority if (i_sum == SUM_MIN) begin
            w_mag = AREA_MAX;
        end else if (i_sum[SUM_BITS-1]) begin
            w_mag = w_neg[AREA_BITS-1:0];
        end else begin
            w_mag = i_sum[AREA_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_area  <= w_mag;
            r_ovf   <= i_sat;
            r_min_x <= i_min_x;
            r_min_y <= i_min_y;
            r_max_x <= i_max_x;
            r_max_y <= i_max_y;
        end
    end

    assign o_valid       = r_valid;
    assign o_twice_area  = r_area;
    assign o_overflowed  = r_ovf;
    assign o_min_x       = r_min_x;
    assign o_min_y       = r_min_y;
    assign o_max_x       = r_max_x;
    assign o_max_y       = r_max_y;
    // every word carries a vertex, so a polygon is never empty
    assign o_no_vertices = 1'b0;

endmodule

FILE: rtl/polygon_area_and_bounds.sv
// channel   dir  modport  word
// i_vtx     in   sink     x, y, last_of_contour, last_of_polygon
// o_res     out  source   twice_area, min_x, min_y, max_x, max_y, no_vertices, overflowed
//
// one vertex accepted per cycle while o_res is not stalled; five register stages:
// A and B in the vertex stage, C and D in the accumulator, then the result register
// the multiplier stage and the saturating 64-bit accumulator set the clock
// i_rst_n is synchronous; it empties the pipe and clears the open polygon
// a stall on o_res holds every stage, and i_vtx.ready drops in the same cycle
// depends on pab_pkg, pab_vertex_if, pab_result_if and the three stage modules
module polygon_area_and_bounds #(parameter int COORD_BITS = 24) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pab_vertex_if.sink  i_vtx,
    pab_result_if.source o_res
);
    import pab_pkg::*;

    localparam int CB = COORD_BITS;

    logic                 w_adv;
    logic                 w_out_valid;
    t_stage_ctl           w_b_ctl, w_d_ctl;
    t_sum                 w_edge, w_close, w_sum;
    logic                 w_sat;
    logic signed [CB-1:0] w_b_min_x, w_b_min_y, w_b_max_x, w_b_max_y;
    logic signed [CB-1:0] w_d_min_x, w_d_min_y, w_d_max_x, w_d_max_y;

    assign w_adv       = !w_out_valid || o_res.ready;
    assign i_vtx.ready = w_adv && i_rst_n;
    assign o_res.valid = w_out_valid;

    pab_vertex_stage #(.COORD_BITS(CB)) u_vertex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_vtx.valid),
        .i_x     (i_vtx.x),
        .i_y     (i_vtx.y),
        .i_eoc   (i_vtx.last_of_contour),
        .i_eop   (i_vtx.last_of_polygon),
        .o_ctl   (w_b_ctl),
        .o_edge  (w_edge),
        .o_close (w_close),
        .o_min_x (w_b_min_x),
        .o_min_y (w_b_min_y),
        .o_max_x (w_b_max_x),
        .o_max_y (w_b_max_y)
    );

    pab_accum #(.COORD_BITS(CB)) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_ctl   (w_b_ctl),
        .i_edge  (w_edge),
        .i_close (w_close),
        .i_min_x (w_b_min_x),
        .i_min_y (w_b_min_y),
        .i_max_x (w_b_max_x),
        .i_max_y (w_b_max_y),
        .o_ctl   (w_d_ctl),
        .o_sum   (w_sum),
        .o_sat   (w_sat),
        .o_min_x (w_d_min_x),
        .o_min_y (w_d_min_y),
        .o_max_x (w_d_max_x),
        .o_max_y (w_d_max_y)
    );

    pab_result #(.COORD_BITS(CB)) u_result (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_ctl         (w_d_ctl),
        .i_sum         (w_sum),
        .i_sat         (w_sat),
        .i_min_x       (w_d_min_x),
        .i_min_y       (w_d_min_y),
        .i_max_x       (w_d_max_x),
        .i_max_y       (w_d_max_y),
        .o_valid       (w_out_valid),
        .o_twice_area  (o_res.twice_area),
        .o_min_x       (o_res.min_x),
        .o_min_y       (o_res.min_y),
        .o_max_x       (o_res.max_x),
        .o_max_y       (o_res.max_y),
        .o_no_vertices (o_res.no_vertices),
        .o_overflowed  (o_res.overflowed)
    );

endmodule
